// ----- hw/rtl/rfp_pkg.sv -----
// Shared types, constants and the Q16.16 multiply for the floor plane intersect.
package rfp_pkg;

   localparam int RFP_NEWTON_STEPS = 16;            // refinement cells in the chain
   localparam logic [31:0] RFP_Q_TWO = 32'h0002_0000; // 2.0 in Q16.16
   localparam int RFP_SIGN_BIT = 31;

   // One ray as it moves down the chain.
   typedef struct packed {
      logic        hit;   // plane is reached
      logic [31:0] org;   // origin height, Q16.16
      logic [31:0] dir;   // direction height, Q16.16
      logic [31:0] inv;   // running reciprocal estimate, Q16.16
   } rfp_ray_type;

   // Truncating Q16.16 multiply: floor(a*b / 2^16), low 32 bits kept.
   function automatic logic [31:0] rfp_qmul(input logic [31:0] a, input logic [31:0] b);
      logic signed [63:0] prod;
      prod = $signed(a) * $signed(b);
      return prod[47:16];
   endfunction

endpackage

// ----- hw/rtl/rfp_newton_cell.sv -----
// One Newton refinement cell: inv = inv * (2 - inv * dir), two register stages.
module rfp_newton_cell
   import rfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  rfp_ray_type in_ray,
   output logic        out_valid,
   input  logic        out_ready,
   output rfp_ray_type out_ray
);

   // stage a: inv * dir
   logic        valid_a_ff;
   rfp_ray_type ray_a_ff;
   logic [31:0] prod_a_ff;
   logic [31:0] prod_a_in;
   // stage b: inv * (2 - inv * dir)
   logic        valid_b_ff;
   rfp_ray_type ray_b_ff;
   rfp_ray_type ray_b_in;
   logic        ready_a;
   logic        ready_b;

   // a stage may take new data when empty or when its content moves on
   assign ready_b  = !valid_b_ff || out_ready;
   assign ready_a  = !valid_a_ff || ready_b;
   assign in_ready = ready_a;

   assign prod_a_in = rfp_qmul(in_ray.inv, in_ray.dir);

   always_comb begin
      ray_b_in     = ray_a_ff;
      ray_b_in.inv = rfp_qmul(ray_a_ff.inv, RFP_Q_TWO - prod_a_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (ready_a) valid_a_ff <= in_valid;
         if (ready_b) valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && in_valid) begin
         ray_a_ff  <= in_ray;
         prod_a_ff <= prod_a_in;
      end
      if (ready_b && valid_a_ff) begin
         ray_b_ff <= ray_b_in;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_ray   = ray_b_ff;

endmodule

// ----- hw/rtl/rfp_scale_stage.sv -----
// Final stage: distance = -(origin * reciprocal), forced to zero on a miss; output register.
module rfp_scale_stage
   import rfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  rfp_ray_type in_ray,
   output logic        out_valid,
   input  logic        out_ready,
   output logic        out_hit,
   output logic [31:0] out_distance
);

   logic        valid_ff;
   logic        hit_ff;
   logic [31:0] dist_ff;
   logic [31:0] dist_in;

   assign in_ready = !valid_ff || out_ready;
   assign dist_in  = in_ray.hit ? (32'd0 - rfp_qmul(in_ray.org, in_ray.inv)) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         hit_ff  <= in_ray.hit;
         dist_ff <= dist_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_hit      = hit_ff;
   assign out_distance = dist_ff;

endmodule

// ----- hw/rtl/ray_floor_plane_intersect.sv -----
// Top level: ray to floor plane intersection through a chain of Newton cells.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-----------------------------------------
//  req     | in  | req_tvalid/req_tready  | tdata[31:0] origin, [63:32] direction
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata[31:0] distance, tuser hit
//
//  One ray per cycle is taken while req_tready is high; each result passes
//  through the two multiplier stages of every Newton cell and then the final
//  scale stage.
//  Reset is synchronous and clears only the valid flags of every stage.
//  A stalled rsp holds its data; stages upstream keep filling bubbles, so req
//  stays ready until every stage of the chain holds a ray.
module ray_floor_plane_intersect
   import rfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] origin_height, [63:32] direction_height
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] distance
   output logic        rsp_tuser    // [0] hit
);

   logic [31:0] req_org;
   logic [31:0] req_dir;
   rfp_ray_type seed_ray;

   logic        chain_valid [RFP_NEWTON_STEPS+1];
   logic        chain_ready [RFP_NEWTON_STEPS+1];
   rfp_ray_type chain_ray   [RFP_NEWTON_STEPS+1];

   assign req_org = req_tdata[31:0];
   assign req_dir = req_tdata[63:32];

   // hit only for a nonzero direction whose sign differs from the origin's;
   // the reciprocal is seeded with the direction itself
   always_comb begin
      seed_ray.hit = (req_dir != 32'd0) &&
                     (req_org[RFP_SIGN_BIT] != req_dir[RFP_SIGN_BIT]);
      seed_ray.org = req_org;
      seed_ray.dir = req_dir;
      seed_ray.inv = req_dir;
   end

   assign chain_valid[0] = req_tvalid;
   assign chain_ray[0]   = seed_ray;
   assign req_tready     = chain_ready[0];

   for (genvar i = 0; i < RFP_NEWTON_STEPS; i++) begin : g_cell
      rfp_newton_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_ray    (chain_ray[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_ray   (chain_ray[i+1])
      );
   end

   rfp_scale_stage u_scale (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (chain_valid[RFP_NEWTON_STEPS]),
      .in_ready     (chain_ready[RFP_NEWTON_STEPS]),
      .in_ray       (chain_ray[RFP_NEWTON_STEPS]),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_hit      (rsp_tuser),
      .out_distance (rsp_tdata)
   );

   // a miss always reports zero distance
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 32'd0)
      else $error("miss with nonzero distance");

   // an empty output stage means the whole chain can advance
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output stage empty");

   // nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the ray to floor plane intersect stream block.
`timescale 1ns / 100ps

module testbench
   import rfp_pkg::*;
();

   // Run length and pacing knobs.
   localparam int unsigned CYCLE_LIMIT   = 400000; // far above the slowest legal run
   localparam int          RANDOM_RAYS   = 1630;
   localparam int          TAIL_RAYS     = 150;    // last rays go out with no idling
   localparam int          HOLD_AFTER    = 400;    // results seen before the long stall
   localparam int          HOLD_CYCLES   = 250;    // long enough to back up the whole chain
   localparam int          DRAIN_CYCLES  = 48;     // longer than the whole chain takes to drain

   // One ray as offered on req: origin height, direction height (Q16.16).
   typedef struct packed {
      logic [31:0] dir;
      logic [31:0] org;
   } ray_item_type;

   // One floor plane result as carried on rsp.
   typedef struct packed {
      logic        hit;
      logic [31:0] distance;
   } floor_hit_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;  // [31:0] origin_height, [63:32] direction_height
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;       // [31:0] distance
   logic        rsp_tuser;       // [0] hit

   ray_item_type  ray_queue[$];     // rays waiting for the driver
   floor_hit_type expected_hits[$]; // predicted results, oldest first

   logic        req_xfer = 1'b0; // req transfer at the last rising edge
   int unsigned cycle_count = 0;
   int          mismatch_count = 0;
   int          results_seen = 0;
   int          hits_seen = 0;
   int          rays_sent = 0;
   int          send_gap = 0;
   int          recv_stall = 0;
   int          long_hold_left = 0;
   logic        long_hold_done = 1'b0;
   logic        tail_phase;
   logic        calm_stretch;

   ray_floor_plane_intersect u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // Reset held from the start, released on a falling edge.
   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
   end

   // Near the end of the stimulus both sides run flat out.
   assign tail_phase   = (ray_queue.size() < TAIL_RAYS);
   // While bit 9 of the cycle count is set, no new random idle bursts start.
   assign calm_stretch = cycle_count[9];

   // Truncating Q16.16 product: floor(a*b / 2^16), low 32 bits kept.
   function automatic logic [31:0] fx_mul(input logic [31:0] a, input logic [31:0] b);
      logic signed [63:0] wide;
      wide = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
      return wide[47:16];
   endfunction

   // Expected result for one ray: Newton reciprocal seeded with the direction.
   function automatic floor_hit_type predict_floor_hit(input logic [31:0] org,
                                                       input logic [31:0] dir);
      floor_hit_type res;
      logic [31:0]   recip;
      res = '0;
      // Only a nonzero direction whose sign differs from the origin's reaches y = 0.
      if (dir != 32'd0 && org[RFP_SIGN_BIT] != dir[RFP_SIGN_BIT]) begin
         recip = dir;
         for (int k = 0; k < RFP_NEWTON_STEPS; k++)
            recip = fx_mul(recip, RFP_Q_TWO - fx_mul(recip, dir));
         res.hit      = 1'b1;
         res.distance = 32'd0 - fx_mul(org, recip); // wraps, no saturation
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR @%0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   task automatic queue_ray(input logic [31:0] org, input logic [31:0] dir);
      ray_item_type item;
      item.org = org;
      item.dir = dir;
      ray_queue.push_back(item);
   endtask

   // Driver: new req content only on a falling edge, and only once the held
   // ray has gone through (or nothing is held).
   always @(negedge clock) begin : drive_req
      ray_item_type next_ray;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_xfer) begin
         if (send_gap > 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (ray_queue.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (!tail_phase && !calm_stretch && $urandom_range(0, 7) == 0) begin
            // random idle burst
            send_gap   <= $urandom_range(0, 17);
            req_tvalid <= 1'b0;
         end else begin
            next_ray   = ray_queue.pop_front();
            req_tdata  <= {next_ray.dir, next_ray.org};
            req_tvalid <= 1'b1;
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off so the chain fills
   // and req_tready has to drop while the driver keeps offering rays.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_left > 0) begin
         long_hold_left <= long_hold_left - 1;
         rsp_tready     <= 1'b0;
      end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
         long_hold_done <= 1'b1;
         long_hold_left <= HOLD_CYCLES - 1;
         rsp_tready     <= 1'b0;
      end else if (tail_phase) begin
         rsp_tready <= 1'b1;
      end else if (recv_stall > 0) begin
         recv_stall <= recv_stall - 1;
         rsp_tready <= 1'b0;
      end else if (!calm_stretch && $urandom_range(0, 9) == 0) begin
         recv_stall <= $urandom_range(0, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor and scoreboard: every transfer is seen on the rising edge.
   always @(posedge clock) begin : monitor
      floor_hit_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still due",
                  cycle_count, expected_hits.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
      req_xfer <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         expected_hits.push_back(predict_floor_hit(req_tdata[31:0], req_tdata[63:32]));
         rays_sent <= rays_sent + 1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         if (rsp_tuser)
            hits_seen <= hits_seen + 1;
         if (expected_hits.size() == 0) begin
            report_mismatch($sformatf("unexpected result hit=%0b distance=%08h",
                                      rsp_tuser, rsp_tdata));
         end else begin
            want = expected_hits.pop_front();
            if (rsp_tuser !== want.hit)
               report_mismatch($sformatf("result %0d: hit %0b, expected %0b",
                                         results_seen, rsp_tuser, want.hit));
            if (rsp_tdata !== want.distance)
               report_mismatch($sformatf("result %0d: distance %08h, expected %08h",
                                         results_seen, rsp_tdata, want.distance));
         end
      end
   end

   // Stimulus: directed corner rays, then random rays, then drain and verdict.
   initial begin : stimulus
      int          sel;
      logic [31:0] org;
      logic [31:0] dir;
      logic [31:0] mag;

      // zero direction never hits, whatever the origin
      queue_ray(32'h0001_0000, 32'h0000_0000);
      queue_ray(32'h8000_0000, 32'h0000_0000);
      // same signs: moving away from the plane
      queue_ray(32'h0001_0000, 32'h0001_0000);
      queue_ray(32'hFFFF_0000, 32'hFFFF_0000);
      queue_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_ray(32'h8000_0000, 32'h8000_0000);
      // origin on the plane: negative direction hits at zero distance, positive one misses
      queue_ray(32'h0000_0000, 32'hFFFF_0000);
      queue_ray(32'h0000_0000, 32'h0001_0000);
      // converging cases around unit magnitude
      queue_ray(32'h0001_0000, 32'hFFFF_0000);
      queue_ray(32'h0003_0000, 32'hFFFF_8000);
      queue_ray(32'hFFFE_0000, 32'h0001_0000);
      queue_ray(32'h0005_0000, 32'hFFFF_4AFB);
      queue_ray(32'hFFFB_0000, 32'h0000_B505);
      // field extremes with opposite signs
      queue_ray(32'h7FFF_FFFF, 32'h8000_0000);
      queue_ray(32'h8000_0000, 32'h7FFF_FFFF);
      queue_ray(32'h7FFF_FFFF, 32'hFFFF_FFFF);
      queue_ray(32'h8000_0000, 32'h0000_0001);
      queue_ray(32'hFFFF_FFFF, 32'h0000_0001);
      queue_ray(32'h0000_0001, 32'hFFFF_FFFF);
      // a slowly converging Newton seed, then a divergent one reported wrapped
      queue_ray(32'h0001_0000, 32'hFFFE_B000);
      queue_ray(32'h0001_0000, 32'hFFF0_0000);

      for (int n = 0; n < RANDOM_RAYS; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 60) begin
            // well-formed hit with a direction the iteration converges on
            mag = $urandom_range(32'h0000_4000, 32'h0001_6000);
            org = $urandom() >> $urandom_range(1, 20);
            if ($urandom_range(0, 1) == 1) begin
               dir = 32'd0 - mag;
            end else begin
               dir = mag;
               org = 32'd0 - org;
            end
         end else if (sel < 75) begin
            // opposite signs, any magnitudes
            org = $urandom();
            dir = $urandom();
            org[31] = ~dir[31];
         end else begin
            org = $urandom();
            dir = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom();
         end
         queue_ray(org, dir);
      end

      while (ray_queue.size() != 0 || req_tvalid || expected_hits.size() != 0)
         @(posedge clock);
      // catch any stray result after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d rays and %0d checked results (%0d hits, %0d misses).",
               rays_sent, results_seen, hits_seen, results_seen - hits_seen);
      $display("Included one %0d-cycle receiver hold-off with the chain backed up.",
               HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/rfp_pkg.sv
hw/rtl/rfp_newton_cell.sv
hw/rtl/rfp_scale_stage.sv
hw/rtl/ray_floor_plane_intersect.sv
dv/testbench.sv
